// ===== design/kbt_pkg.sv =====
`timescale 1ns / 1ps

package kbt_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned ModeW    = 2;
  localparam int unsigned TableSelW = 5;
  localparam int unsigned KeyW     = 16;
  localparam int unsigned ModsW    = 8;
  localparam int unsigned CmdW     = 9;
  localparam int unsigned LinkW    = 5;
  localparam int unsigned StatusW  = 3;

  // Item modes
  localparam logic [ModeW-1:0] MODE_BIND_CMD  = 2'd0;
  localparam logic [ModeW-1:0] MODE_BIND_LINK = 2'd1;
  localparam logic [ModeW-1:0] MODE_LOOKUP    = 2'd2;
  localparam logic [ModeW-1:0] MODE_CLEAR     = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] ST_UPDATED  = 3'd0;
  localparam logic [StatusW-1:0] ST_INSERTED = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd2;
  localparam logic [StatusW-1:0] ST_HIT      = 3'd3;
  localparam logic [StatusW-1:0] ST_MISS     = 3'd4;
  localparam logic [StatusW-1:0] ST_CLEARED  = 3'd5;

  typedef struct packed {
    logic [ModeW-1:0]     mode;
    logic [TableSelW-1:0] table_sel;
    logic [KeyW-1:0]      key_code;
    logic [ModsW-1:0]     modifier_mask;
    logic [CmdW-1:0]      command_num;
    logic [LinkW-1:0]     link_table;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               is_prefix;
    logic [CmdW-1:0]    found_command;
    logic [LinkW-1:0]   found_link;
  } out_item_t;

  // One binding as held in the entry memory
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [ModsW-1:0] mods;
    logic             is_link;
    logic [CmdW-1:0]  command;
    logic [LinkW-1:0] link;
  } entry_t;

endpackage

// ===== design/key_binding_table.sv =====
`timescale 1ns / 1ps

// Key binding table: TABLE_COUNT tables of up to ENTRIES_PER_TABLE bindings,
// each matched on key code plus modifier mask.
// Input channel (in_valid_i / in_stall_o / in_item_i): one beat per item;
// mode selects bind command, bind prefix link, lookup or clear table.
// Output channel (out_valid_o / out_stall_i / out_item_o): exactly one
// result beat per item, in item order.
// Timing: the block works on one item at a time. After acceptance it reads
// the table's fill count, scans the entry memory one entry per cycle
// through its single read port, stopping early on a match, then writes
// back and loads the result register in its done step. The scan over the
// entry memory sets how long an item takes; clears skip the scan.
// The result register parts the two channels: the next item is taken while
// a result still waits. A stalled result holds; a finished item then waits
// in its write-back step until the register frees, and no new beat is taken.
// Reset empties every table at once through per-table valid bits on the
// fill counts; the entry memory is not cleared, as only entries below a
// table's fill count are ever read.
module key_binding_table #(
  parameter int unsigned ENTRIES_PER_TABLE = 64,
  parameter int unsigned TABLE_COUNT       = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kbt_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kbt_pkg::out_item_t   out_item_o
);

  localparam int unsigned Slots = TABLE_COUNT * ENTRIES_PER_TABLE;
  localparam int unsigned AW    = $clog2(Slots);
  localparam int unsigned TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int unsigned TXW   = (TW > kbt_pkg::TableSelW) ? TW : kbt_pkg::TableSelW;
  localparam int unsigned CW    = $clog2(ENTRIES_PER_TABLE + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]              state_q, state_d;
  kbt_pkg::in_item_t       item_q;
  logic                    tvalid_q;
  logic [TW-1:0]           tbl_q;
  logic [AW-1:0]           base_q;
  logic [CW-1:0]           cnt_q;
  logic [CW-1:0]           idx_q;
  logic                    rd_pend_q;
  logic [AW-1:0]           rd_addr_q;
  logic                    hit_q;
  logic [AW-1:0]           hit_addr_q;
  kbt_pkg::entry_t         hit_ent_q;
  logic                    out_valid_q;
  kbt_pkg::out_item_t      out_q;
  logic [TABLE_COUNT-1:0]  fvalid_q;

  // Fill-count memory and entry memory, both with registered read data
  logic [CW-1:0]           fill_mem [TABLE_COUNT];
  logic [CW-1:0]           fill_rdata_q;
  kbt_pkg::entry_t         ent_mem [Slots];
  kbt_pkg::entry_t         ent_rdata_q;

  logic [TXW-1:0]          sel_ext;
  logic [TW-1:0]           sel_idx;
  logic                    sel_valid;
  logic                    accept;
  logic                    done;
  logic                    match;
  logic                    issue;
  logic                    full;
  logic                    is_bind;
  logic                    do_write;
  logic [AW-1:0]           wr_addr;
  kbt_pkg::entry_t         wr_ent;
  kbt_pkg::out_item_t      res;

  assign sel_ext   = TXW'(in_item_i.table_sel);
  assign sel_idx   = sel_ext[TW-1:0];
  assign sel_valid = (32'(in_item_i.table_sel) < TABLE_COUNT);

  // Take a beat only between items
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Finish once the result register is free or being emptied
  assign done = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign match = rd_pend_q && (ent_rdata_q.key == item_q.key_code)
                 && (ent_rdata_q.mods == item_q.modifier_mask);
  assign issue = (state_q == S_SCAN) && !match && (idx_q < cnt_q);

  assign is_bind = (item_q.mode == kbt_pkg::MODE_BIND_CMD)
                   || (item_q.mode == kbt_pkg::MODE_BIND_LINK);
  assign full    = !tvalid_q || (cnt_q >= CW'(ENTRIES_PER_TABLE));

  // New binding word; the unused payload field is zeroed
  always_comb begin
    wr_ent         = '0;
    wr_ent.key     = item_q.key_code;
    wr_ent.mods    = item_q.modifier_mask;
    wr_ent.is_link = (item_q.mode == kbt_pkg::MODE_BIND_LINK);
    if (wr_ent.is_link) begin
      wr_ent.link = item_q.link_table;
    end else begin
      wr_ent.command = item_q.command_num;
    end
  end

  // Overwrite in place on a hit, else append at the fill count
  assign wr_addr  = hit_q ? hit_addr_q : (base_q + AW'(cnt_q));
  assign do_write = done && is_bind && (hit_q || !full);

  always_comb begin
    res = '0;
    case (item_q.mode)
      kbt_pkg::MODE_CLEAR: begin
        res.status = kbt_pkg::ST_CLEARED;
      end
      kbt_pkg::MODE_LOOKUP: begin
        if (hit_q) begin
          res.status    = kbt_pkg::ST_HIT;
          res.is_prefix = hit_ent_q.is_link;
          if (hit_ent_q.is_link) begin
            res.found_link = hit_ent_q.link;
          end else begin
            res.found_command = hit_ent_q.command;
          end
        end else begin
          res.status = kbt_pkg::ST_MISS;
        end
      end
      default: begin
        if (hit_q) begin
          res.status = kbt_pkg::ST_UPDATED;
        end else if (full) begin
          res.status = kbt_pkg::ST_FULL;
        end else begin
          res.status = kbt_pkg::ST_INSERTED;
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        state_d = (item_q.mode == kbt_pkg::MODE_CLEAR) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (match || (idx_q >= cnt_q)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fvalid_q    <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= issue;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (done && tvalid_q) begin
        if (item_q.mode == kbt_pkg::MODE_CLEAR) begin
          fvalid_q[tbl_q] <= 1'b0;
        end else if (do_write && !hit_q) begin
          fvalid_q[tbl_q] <= 1'b1;
        end
      end
    end
  end

  // Item payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q   <= in_item_i;
      tvalid_q <= sel_valid;
      tbl_q    <= sel_idx;
      base_q   <= AW'(sel_idx) * AW'(ENTRIES_PER_TABLE);
      hit_q    <= 1'b0;
    end
    if (state_q == S_FILL) begin
      cnt_q <= (tvalid_q && fvalid_q[tbl_q]) ? fill_rdata_q : '0;
      idx_q <= '0;
    end
    if (issue) begin
      rd_addr_q <= base_q + AW'(idx_q);
      idx_q     <= idx_q + CW'(1);
    end
    if ((state_q == S_SCAN) && match) begin
      hit_q      <= 1'b1;
      hit_addr_q <= rd_addr_q;
      hit_ent_q  <= ent_rdata_q;
    end
    if (done) begin
      out_q <= res;
    end
  end

  // Fill-count memory: read at acceptance, write back an append
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fill_rdata_q <= fill_mem[sel_idx];
    end
    if (do_write && !hit_q) begin
      fill_mem[tbl_q] <= cnt_q + CW'(1);
    end
  end

  // Entry memory: one read and one write port
  always_ff @(posedge clk_i) begin
    if (issue) begin
      ent_rdata_q <= ent_mem[base_q + AW'(idx_q)];
    end
    if (do_write) begin
      ent_mem[wr_addr] <= wr_ent;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= CW'(ENTRIES_PER_TABLE)))
    else $error("fill count above table size");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= cnt_q))
    else $error("scan index past fill count");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ($past(state_q) == S_SCAN))
    else $error("entry read outside scan");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised without a finished item");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !accept)
    else $error("beat taken while an item is in work");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kbt_pkg::*;

  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned TABLES   = 32;
  localparam int unsigned QUIET_LIMIT = 5000;  // cycles with no beat on either side
  localparam int unsigned TAIL_CYCLES = 100;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Own copy of the binding store
  int unsigned fill_level [TABLES];
  entry_t      bindings   [TABLES*ENTRIES];

  out_item_t   expected_answers[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;

  logic [KeyW-1:0]  key_pool  [16];
  logic [ModsW-1:0] mods_pool [4];
  logic [TableSelW-1:0] hot_tables [4];

  key_binding_table #(
    .ENTRIES_PER_TABLE(ENTRIES),
    .TABLE_COUNT      (TABLES)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #4 clk = ~clk;

  // Work out the answer to one item and update the store as the block would.
  function automatic out_item_t binding_outcome(in_item_t it);
    out_item_t res;
    int        slot;
    int        base;
    int        n;
    bit        live;
    res  = '0;
    slot = -1;
    live = (it.table_sel < TABLES);
    if (live && it.mode != MODE_CLEAR) begin
      base = it.table_sel * ENTRIES;
      n    = fill_level[it.table_sel];
      for (int i = 0; i < n; i++) begin
        if (slot < 0 && bindings[base+i].key == it.key_code &&
            bindings[base+i].mods == it.modifier_mask) begin
          slot = base + i;
        end
      end
    end
    case (it.mode)
      MODE_CLEAR: begin
        if (live) fill_level[it.table_sel] = 0;
        res.status = ST_CLEARED;
      end
      MODE_LOOKUP: begin
        if (slot < 0) begin
          res.status = ST_MISS;
        end else begin
          res.status = ST_HIT;
          if (bindings[slot].is_link) begin
            res.is_prefix  = 1'b1;
            res.found_link = bindings[slot].link;
          end else begin
            res.found_command = bindings[slot].command;
          end
        end
      end
      default: begin
        if (slot >= 0) begin
          res.status = ST_UPDATED;
        end else if (!live || fill_level[it.table_sel] >= ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          slot = it.table_sel * ENTRIES + fill_level[it.table_sel];
          fill_level[it.table_sel]++;
          bindings[slot].key  = it.key_code;
          bindings[slot].mods = it.modifier_mask;
          res.status = ST_INSERTED;
        end
        if (slot >= 0) begin
          // rebinding switches the kind and zeroes the unused payload
          bindings[slot].is_link = (it.mode == MODE_BIND_LINK);
          bindings[slot].command = (it.mode == MODE_BIND_LINK) ? '0 : it.command_num;
          bindings[slot].link    = (it.mode == MODE_BIND_LINK) ? it.link_table : '0;
        end
      end
    endcase
    return res;
  endfunction

  function automatic in_item_t make_item(logic [ModeW-1:0] mode, int tsel, int key,
                                         int mods, int cmd, int link);
    in_item_t it;
    it.mode          = mode;
    it.table_sel     = TableSelW'(tsel);
    it.key_code      = KeyW'(key);
    it.modifier_mask = ModsW'(mods);
    it.command_num   = CmdW'(cmd);
    it.link_table    = LinkW'(link);
    return it;
  endfunction

  // Mostly binds and lookups on a small set of tables and key chords, so that
  // hits, rebinds and full tables come up often; the rest is open noise.
  function automatic in_item_t random_keystroke();
    in_item_t    it;
    int unsigned pick;
    it.command_num = CmdW'($urandom_range(0, 511));
    it.link_table  = LinkW'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 36)      it.mode = MODE_BIND_CMD;
    else if (pick < 56) it.mode = MODE_BIND_LINK;
    else if (pick < 98) it.mode = MODE_LOOKUP;
    else                it.mode = MODE_CLEAR;
    it.table_sel = ($urandom_range(0, 99) < 65) ? hot_tables[$urandom_range(0, 3)]
                                                : TableSelW'($urandom_range(0, 31));
    it.key_code  = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, 15)]
                                                : KeyW'($urandom_range(0, 65535));
    it.modifier_mask = ($urandom_range(0, 99) < 70) ? mods_pool[$urandom_range(0, 3)]
                                                    : ModsW'($urandom_range(0, 255));
    return it;
  endfunction

  // Offer one beat after a random gap and hold it until accepted.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    expected_answers.push_back(binding_outcome(it));
  endtask

  task automatic park_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d prefix %0d cmd %0d link %0d",
                   out_item.status, out_item.is_prefix, out_item.found_command,
                   out_item.found_link);
      end else begin
        want = expected_answers.pop_front();
        if (out_item.status !== want.status || out_item.is_prefix !== want.is_prefix ||
            out_item.found_command !== want.found_command ||
            out_item.found_link !== want.found_link) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d prefix %0d/%0d cmd %0d/%0d link %0d/%0d",
                     want.status, out_item.status, want.is_prefix, out_item.is_prefix,
                     want.found_command, out_item.found_command,
                     want.found_link, out_item.found_link);
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(make_item(MODE_LOOKUP,    0,  16'h0000, 8'h00, 0, 0));    // empty table
    send_item(make_item(MODE_BIND_CMD,  31, 16'hFFFF, 8'hFF, 511, 31));
    send_item(make_item(MODE_LOOKUP,    31, 16'hFFFF, 8'hFF, 0, 0));
    // rebind as a link: the command field must come back as zero
    send_item(make_item(MODE_BIND_LINK, 31, 16'hFFFF, 8'hFF, 511, 31));
    send_item(make_item(MODE_LOOKUP,    31, 16'hFFFF, 8'hFF, 0, 0));
    send_item(make_item(MODE_BIND_CMD,  31, 16'hFFFF, 8'hFF, 0, 31));
    send_item(make_item(MODE_LOOKUP,    31, 16'hFFFF, 8'hFF, 0, 0));
    send_item(make_item(MODE_BIND_CMD,  0,  16'h0000, 8'h00, 9'h155, 0));
    send_item(make_item(MODE_LOOKUP,    0,  16'h0000, 8'h01, 0, 0));    // mods differ
    send_item(make_item(MODE_LOOKUP,    0,  16'h0001, 8'h00, 0, 0));    // key differs
    send_item(make_item(MODE_BIND_LINK, 0,  16'h0000, 8'h80, 9'h0AA, 0));
    send_item(make_item(MODE_BIND_LINK, 0,  16'h8000, 8'h80, 0, 5'h15));
    send_item(make_item(MODE_LOOKUP,    0,  16'h0000, 8'h80, 0, 0));
    send_item(make_item(MODE_LOOKUP,    0,  16'h0000, 8'h00, 0, 0));
    send_item(make_item(MODE_LOOKUP,    0,  16'h8000, 8'h80, 0, 0));
    send_item(make_item(MODE_CLEAR,     31, 16'hFFFF, 8'hFF, 511, 31));
    send_item(make_item(MODE_LOOKUP,    31, 16'hFFFF, 8'hFF, 0, 0));
    send_item(make_item(MODE_CLEAR,     5,  16'h0000, 8'h00, 0, 0));    // already empty
    send_item(make_item(MODE_BIND_CMD,  31, 16'h1234, 8'h5A, 9'h0F0, 0));
    send_item(make_item(MODE_LOOKUP,    31, 16'h1234, 8'h5A, 0, 0));
  endtask

  // Fill one hot table to the brim, then probe the full case; leave it full.
  task automatic test_table_full();
    logic [KeyW-1:0]  base;
    logic [ModsW-1:0] mods;
    logic [TableSelW-1:0] tsel;
    base = KeyW'($urandom_range(0, 65535));
    mods = ModsW'($urandom_range(0, 255));
    tsel = hot_tables[2];
    send_idle_pct = 9;
    stall_pct     = 9;
    send_item(make_item(MODE_CLEAR, tsel, 0, 0, 0, 0));
    for (int i = 0; i < ENTRIES; i++)
      send_item(make_item((i % 3 == 0) ? MODE_BIND_LINK : MODE_BIND_CMD, tsel,
                          {base[15:6], i[5:0]}, mods, $urandom_range(0, 511),
                          $urandom_range(0, 31)));
    send_item(make_item(MODE_BIND_CMD, tsel, {~base[15:6], 6'd0}, mods, 7, 0));
    send_item(make_item(MODE_BIND_LINK, tsel, {base[15:6], 6'd63}, mods, 0, 3));
    send_item(make_item(MODE_LOOKUP, tsel, {base[15:6], 6'd63}, mods, 0, 0));
    send_item(make_item(MODE_LOOKUP, tsel, {base[15:6], 6'd0}, mods, 0, 0));
    send_item(make_item(MODE_LOOKUP, tsel, {~base[15:6], 6'd0}, mods, 0, 0));
  endtask

  task automatic test_random_phase(int unsigned send_pct, int unsigned recv_pct,
                                   int unsigned count);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    repeat (count) send_item(random_keystroke());
  endtask

  // Hold the result side off while beats keep coming, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 400;
    repeat (30) send_item(random_keystroke());
  endtask

  // Pause the sender until every answer is back, then resume.
  task automatic test_drain_pause();
    send_idle_pct = 9;
    stall_pct     = 9;
    repeat (15) send_item(random_keystroke());
    park_sender();
    wait_drained();
    repeat (15) send_item(random_keystroke());
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    out_stall     = 1'b0;
    mismatches    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    for (int t = 0; t < TABLES; t++) fill_level[t] = 0;
    for (int k = 0; k < 16; k++) key_pool[k] = KeyW'($urandom_range(0, 65535));
    for (int m = 0; m < 4; m++) mods_pool[m] = ModsW'($urandom_range(0, 255));
    hot_tables[0] = 5'd0;
    hot_tables[1] = 5'd1;
    hot_tables[2] = 5'd30;
    hot_tables[3] = 5'd31;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_full();
    test_random_phase(0, 0, 440);
    test_random_phase(76, 0, 440);
    test_random_phase(0, 76, 440);
    test_random_phase(9, 9, 440);
    test_backpressure();
    test_drain_pause();

    park_sender();
    send_idle_pct = 0;
    stall_pct     = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d answers outstanding", mismatches,
               expected_answers.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
